// ===== sv/cms_pkg.sv =====
`default_nettype none
package cms_pkg;

   localparam int HASH_W       = 64;
   localparam int BUCKET_W     = 32;
   localparam int TOTAL_W      = 64;
   localparam int CFG_W        = 11;
   localparam int ROWS_CFG_W   = 3;
   localparam int ROWS_MAX_DEF  = 4;
   localparam int WIDTH_MAX_DEF = 1024;
   localparam int ROW_WIDTH_RESET = 1024;
   localparam int ROW_COUNT_RESET = 4;

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [HASH_W-1:0] SEED_STEP = 64'd31;

   localparam logic REG_ROW_WIDTH = 1'b0;
   localparam logic REG_ROW_COUNT = 1'b1;

   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   localparam logic [BUCKET_W-1:0] BUCKET_FULL = '1;

   function automatic logic [HASH_W-1:0] row_seed(input int unsigned row);
      row_seed = FNV_BASIS + SEED_STEP * HASH_W'(row);
   endfunction

   // The prime is 2^40 + 0x1B3, so the product is one shift and a narrow
   // constant multiple.
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {56'd0, b};
      fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                 + (x << 1) + x;
   endfunction

endpackage
`default_nettype wire

// ===== sv/cms_rem.sv =====
`default_nettype none
module cms_rem #(
   parameter int ROWS_MAX = cms_pkg::ROWS_MAX_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [cms_pkg::HASH_W-1:0] dividend [ROWS_MAX],
   input  wire logic [cms_pkg::CFG_W-1:0] divisor,
   output logic done,
   output logic [cms_pkg::CFG_W-1:0] remainder [ROWS_MAX]
);

   localparam int STEP_W = $clog2(cms_pkg::HASH_W);

   logic [cms_pkg::HASH_W-1:0] quot_ff [ROWS_MAX];
   logic [cms_pkg::CFG_W-1:0]  rem_ff  [ROWS_MAX];
   logic [cms_pkg::CFG_W-1:0]  div_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       busy_ff;
   logic                       done_ff;

   // One quotient bit per cycle in every lane; all lanes share the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(cms_pkg::HASH_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [cms_pkg::CFG_W:0] shifted;
      if (start) begin
         div_ff <= divisor;
         for (int r = 0; r < ROWS_MAX; r++) begin
            quot_ff[r] <= dividend[r];
            rem_ff[r]  <= '0;
         end
      end else if (busy_ff) begin
         for (int r = 0; r < ROWS_MAX; r++) begin
            shifted = {rem_ff[r], quot_ff[r][cms_pkg::HASH_W-1]};
            if (shifted >= {1'b0, div_ff}) begin
               shifted = shifted - {1'b0, div_ff};
            end
            rem_ff[r]  <= shifted[cms_pkg::CFG_W-1:0];
            quot_ff[r] <= quot_ff[r] << 1;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== sv/count_min_sketch_update_probe_top.sv =====
`default_nettype none
// Channel   Direction  Signals                         Contents
// req       in         tvalid tready tdata tuser tlast  key byte, operation/has_byte, last
// rsp       out        tvalid tready tdata              estimate, element total
// csr       in         we index wdata                   row_width, row_count
//
// Key bytes are taken one per cycle while no key is in flight. The request that ends a key
// starts a 64-step bit-serial remainder over all rows; each used row then passes through
// a bucket read and, for a count, a write-back, and then the response is loaded. No
// request is taken from that request until its response is loaded.
// After reset all ROWS_MAX * WIDTH_MAX bucket entries are cleared, one entry a cycle,
// during which no request is taken. A stalled response blocks requests only once the
// next key has ended and its response is ready to load.
module count_min_sketch_update_probe_top #(
   parameter int ROWS_MAX  = cms_pkg::ROWS_MAX_DEF,
   parameter int WIDTH_MAX = cms_pkg::WIDTH_MAX_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [7:0] req_tdata,   // key_byte
   input  wire logic [1:0] req_tuser,   // operation, has_byte
   input  wire logic req_tlast,         // last_byte
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [95:0] rsp_tdata,       // estimate, element_total
   input  wire logic csr_we,
   input  wire logic csr_index,
   input  wire logic [cms_pkg::CFG_W-1:0] csr_wdata
);

   localparam int DEPTH  = ROWS_MAX * WIDTH_MAX;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RIDX_W = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;

   typedef enum logic [2:0] {S_CLEAR, S_RUN, S_DIV, S_READ, S_MODIFY, S_OUT} state_type;

   state_type state_ff;
   logic [cms_pkg::CFG_W-1:0]      row_width_ff;
   logic [cms_pkg::ROWS_CFG_W-1:0] row_count_ff;
   logic [cms_pkg::HASH_W-1:0]     hash_ff [ROWS_MAX];
   logic [cms_pkg::HASH_W-1:0]     hash_in [ROWS_MAX];
   logic [ADDR_W-1:0]              clr_ff;
   logic [RIDX_W-1:0]              row_ff;
   logic [RIDX_W-1:0]              row_last_ff;
   logic                           op_ff;
   logic [cms_pkg::BUCKET_W-1:0]   min_ff;
   logic [cms_pkg::TOTAL_W-1:0]    total_ff;
   logic                           rsp_valid_ff;
   logic [95:0]                    rsp_data_ff;

   logic [cms_pkg::BUCKET_W-1:0] mem [DEPTH];
   logic [cms_pkg::BUCKET_W-1:0] rd_data_ff;
   logic                         mem_we;
   logic [ADDR_W-1:0]            mem_addr;
   logic [cms_pkg::BUCKET_W-1:0] mem_wdata;

   logic                       accept;
   logic                       div_start;
   logic                       div_done;
   logic [cms_pkg::CFG_W-1:0]  width_used;
   logic [RIDX_W-1:0]          rows_last;
   logic [cms_pkg::CFG_W-1:0]  rem [ROWS_MAX];
   logic [ADDR_W-1:0]          bucket_addr;

   assign accept    = req_tvalid && req_tready;
   assign div_start = accept && req_tlast;

   always_comb begin
      for (int r = 0; r < ROWS_MAX; r++) begin
         hash_in[r] = req_tuser[1] ? cms_pkg::fnv_step(hash_ff[r], req_tdata) : hash_ff[r];
      end
   end

   always_comb begin
      width_used = row_width_ff;
      if (row_width_ff == '0) begin
         width_used = cms_pkg::CFG_W'(1);
      end else if (32'(row_width_ff) > WIDTH_MAX) begin
         width_used = cms_pkg::CFG_W'(WIDTH_MAX);
      end
      rows_last = RIDX_W'(row_count_ff - 1'b1);
      if (row_count_ff == '0) begin
         rows_last = '0;
      end else if (32'(row_count_ff) > ROWS_MAX) begin
         rows_last = RIDX_W'(ROWS_MAX - 1);
      end
   end

   cms_rem #(.ROWS_MAX(ROWS_MAX)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hash_in),
      .divisor   (width_used),
      .done      (div_done),
      .remainder (rem)
   );

   assign bucket_addr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(WIDTH_MAX)) + ADDR_W'(rem[row_ff]);

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = bucket_addr;
      mem_wdata = rd_data_ff;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_addr  = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == S_MODIFY && op_ff == cms_pkg::OP_COUNT) begin
         mem_we = 1'b1;
         if (rd_data_ff != cms_pkg::BUCKET_FULL) begin
            mem_wdata = rd_data_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= cms_pkg::CFG_W'(cms_pkg::ROW_WIDTH_RESET);
         row_count_ff <= cms_pkg::ROWS_CFG_W'(cms_pkg::ROW_COUNT_RESET);
      end else if (csr_we) begin
         case (csr_index)
            cms_pkg::REG_ROW_WIDTH: row_width_ff <= csr_wdata;
            cms_pkg::REG_ROW_COUNT: row_count_ff <= csr_wdata[cms_pkg::ROWS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         row_ff       <= '0;
         row_last_ff  <= '0;
         op_ff        <= cms_pkg::OP_COUNT;
         min_ff       <= '1;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < ROWS_MAX; r++) begin
            hash_ff[r] <= cms_pkg::row_seed(r);
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (accept) begin
                  if (req_tlast) begin
                     // The divider has captured the finished hashes.
                     for (int r = 0; r < ROWS_MAX; r++) begin
                        hash_ff[r] <= cms_pkg::row_seed(r);
                     end
                     op_ff       <= req_tuser[0];
                     row_last_ff <= rows_last;
                     min_ff      <= '1;
                     state_ff    <= S_DIV;
                  end else begin
                     hash_ff <= hash_in;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  row_ff   <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_MODIFY;
            end
            S_MODIFY: begin
               if (rd_data_ff < min_ff) begin
                  min_ff <= rd_data_ff;
               end
               if (row_ff == row_last_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  if (op_ff == cms_pkg::OP_COUNT) begin
                     total_ff    <= total_ff + 1'b1;
                     rsp_data_ff <= {total_ff + 1'b1, 32'd0};
                  end else begin
                     rsp_data_ff <= {total_ff, min_ff};
                  end
                  state_ff <= S_RUN;
               end
            end
            default: state_ff <= S_RUN;
         endcase
      end
   end

   assign req_tready = (state_ff == S_RUN);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== verif/tb_count_min_sketch_update_probe_top.sv =====
`default_nettype none
module tb_count_min_sketch_update_probe_top;

   localparam int ROWS_N  = cms_pkg::ROWS_MAX_DEF;
   localparam int WIDTH_N = cms_pkg::WIDTH_MAX_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic       op;
      logic [7:0] key_byte;
      logic       has_byte;
      logic       last_byte;
   } request_type;

   // Estimate sits in the low bits, as on the response bus.
   typedef struct packed {
      logic [63:0] total;
      logic [31:0] estimate;
   } answer_type;

   // Directed rows: fixed marks that the answer is typed in rather than predicted.
   typedef struct {
      request_type req;
      logic        fixed;
      answer_type  ans;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic csr_index = cms_pkg::REG_ROW_WIDTH;
   logic [cms_pkg::CFG_W-1:0] csr_wdata = '0;

   count_min_sketch_update_probe_top DUT (.*);

   logic [63:0] hash_q [ROWS_N];
   logic [31:0] sketch_q [ROWS_N*WIDTH_N];
   logic [63:0] counted_keys;
   logic [10:0] width_q;
   logic [2:0]  rows_q;
   answer_type  pending_answers [$];
   bit          failed = 0;
   bit          quiet_mode = 0;
   int          idle_cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void reseed();
      for (int r = 0; r < ROWS_N; r++)
         hash_q[r] = cms_pkg::FNV_BASIS + cms_pkg::SEED_STEP * 64'(r);
   endfunction

   // Applies one request to the shadow sketch; returns 1 with the answer if one is due.
   function automatic bit sketch_step(input request_type q, output answer_type a);
      int unsigned w, n, slot;
      logic [31:0] lowest;
      lowest = '1;
      a = '0;
      if (q.has_byte)
         for (int r = 0; r < ROWS_N; r++)
            hash_q[r] = (hash_q[r] ^ 64'(q.key_byte)) * 64'd1099511628211;
      if (!q.last_byte) return 0;
      w = (width_q == 0) ? 1 : (width_q > WIDTH_N) ? WIDTH_N : width_q;
      n = (rows_q == 0) ? 1 : (rows_q > ROWS_N) ? ROWS_N : rows_q;
      for (int r = 0; r < n; r++) begin
         slot = r * WIDTH_N + int'(hash_q[r] % 64'(w));
         if (q.op == cms_pkg::OP_COUNT) begin
            if (sketch_q[slot] != cms_pkg::BUCKET_FULL) sketch_q[slot]++;
         end else if (sketch_q[slot] < lowest) begin
            lowest = sketch_q[slot];
         end
      end
      if (q.op == cms_pkg::OP_COUNT) begin
         counted_keys++;
         a.estimate = '0;
      end else begin
         a.estimate = lowest;
      end
      a.total = counted_keys;
      reseed();
      return 1;
   endfunction

   task automatic send_request(input request_type q, input bit fixed, input answer_type fa);
      answer_type a;
      while (!quiet_mode && $urandom_range(99) < 20) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = q.key_byte;
      req_tuser  = {q.has_byte, q.op};
      req_tlast  = q.last_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sketch_step(q, a)) pending_answers.push_back(fixed ? fa : a);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain();
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [cms_pkg::CFG_W-1:0] v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == cms_pkg::REG_ROW_WIDTH) width_q = v;
      else rows_q = v[2:0];
   endtask

   function automatic request_type mk(input logic op, input logic [7:0] b, input logic h,
                                      input logic l);
      request_type q;
      q.op = op; q.key_byte = b; q.has_byte = h; q.last_byte = l;
      return q;
   endfunction

   task automatic random_key();
      int len;
      len = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
         send_request(mk(1'($urandom_range(1)), 8'($urandom), 1'b1, 1'b0), 1'b0, '0);
         if ($urandom_range(9) == 0)
            send_request(mk(1'($urandom_range(1)), 8'($urandom), 1'b0, 1'b0), 1'b0, '0);
      end
      send_request(mk(1'($urandom_range(1)), 8'($urandom),
                      len == 0 ? 1'($urandom) : 1'b1, 1'b1), 1'b0, '0);
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_tready <= quiet_mode || ($urandom_range(99) >= 20);
   end

   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            failed = 1;
         end else begin
            want = pending_answers.pop_front();
            if (got.estimate !== want.estimate) begin
               $display("%0t: estimate expected %h actual %h", $time, want.estimate,
                        got.estimate);
               failed = 1;
            end
            if (got.total !== want.total) begin
               $display("%0t: element total expected %h actual %h", $time, want.total,
                        got.total);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("** count_min_sketch_update_probe_top: FAILED **");
         $finish;
      end
   end

   initial begin
      step_row_type steps [$];
      step_row_type s;
      answer_type z;
      int n;
      int unsigned widths [6];
      int unsigned rowsets [6];
      widths = '{1, 1024, 2, 7, 0, 2047};
      rowsets = '{4, 1, 2, 0, 7, 3};
      width_q = 11'(cms_pkg::ROW_WIDTH_RESET);
      rows_q = 3'(cms_pkg::ROW_COUNT_RESET);
      counted_keys = '0;
      reseed();
      foreach (sketch_q[i]) sketch_q[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Probe of an empty key on a cleared sketch, then count and probe it.
      z = '0;
      s.fixed = 1; s.ans = z;
      s.req = mk(cms_pkg::OP_PROBE, 8'h00, 1'b0, 1'b1); steps.push_back(s);
      s.req = mk(cms_pkg::OP_COUNT, 8'hFF, 1'b0, 1'b1);
      s.ans.estimate = 32'd0; s.ans.total = 64'd1; steps.push_back(s);
      s.req = mk(cms_pkg::OP_PROBE, 8'h00, 1'b0, 1'b1);
      s.ans.estimate = 32'd1; s.ans.total = 64'd1; steps.push_back(s);
      s.fixed = 0;
      s.req = mk(cms_pkg::OP_COUNT, 8'h00, 1'b0, 1'b0); steps.push_back(s);
      s.req = mk(cms_pkg::OP_COUNT, 8'hFF, 1'b1, 1'b0); steps.push_back(s);
      s.req = mk(cms_pkg::OP_COUNT, 8'h00, 1'b1, 1'b1); steps.push_back(s);
      s.req = mk(cms_pkg::OP_PROBE, 8'hFF, 1'b1, 1'b0); steps.push_back(s);
      s.req = mk(cms_pkg::OP_PROBE, 8'h00, 1'b1, 1'b1); steps.push_back(s);
      s.req = mk(cms_pkg::OP_PROBE, 8'hA5, 1'b1, 1'b1); steps.push_back(s);
      s.req = mk(cms_pkg::OP_COUNT, 8'h5A, 1'b1, 1'b1); steps.push_back(s);
      s.req = mk(cms_pkg::OP_PROBE, 8'h5A, 1'b1, 1'b1); steps.push_back(s);
      foreach (steps[i]) send_request(steps[i].req, steps[i].fixed, steps[i].ans);
      drain();

      // Each pass writes a new width and row count only once every answer has come back.
      n = 0;
      foreach (widths[p]) begin
         write_reg(cms_pkg::REG_ROW_WIDTH, cms_pkg::CFG_W'(widths[p]));
         write_reg(cms_pkg::REG_ROW_COUNT, cms_pkg::CFG_W'(rowsets[p]));
         quiet_mode = (p == 2);
         for (int k = 0; k < 105; k++) random_key();
         quiet_mode = 0;
         drain();
      end

      if (!failed) begin
         $display("** count_min_sketch_update_probe_top: PASSED **");
      end else begin
         $display("** count_min_sketch_update_probe_top: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
